### rtl/tcf_pkg.sv
// ----------------------------------------------------------------------------
// Tree centre finder package
// Shared widths, codes, command and status types for the tree centre finder.
// ----------------------------------------------------------------------------
package tcf_pkg;

   // Field widths.
   localparam int LABEL_W    = 10;
   localparam int COUNT_W    = 11;
   localparam int DEG_W      = 10;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Register index, taken from the word address bit of the configuration port.
   localparam logic REG_NODE_COUNT = 1'b0;

   // Request function codes.
   localparam logic FUNC_EDGE = 1'b0;
   localparam logic FUNC_FIND = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EDGE_A,
      ST_EDGE_B,
      ST_FIND,
      ST_SCAN,
      ST_LEVEL,
      ST_TRIM_Q,
      ST_TRIM_C,
      ST_TRIM_K,
      ST_TRIM_N,
      ST_TRIM_W,
      ST_SEL_INIT,
      ST_SEL,
      ST_LOAD,
      ST_EMIT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_EDGE_A,
      OP_EDGE_B,
      OP_FIND_INIT,
      OP_SCAN,
      OP_LEVEL,
      OP_TRIM_RQ,
      OP_TRIM_RC,
      OP_TRIM_CHK,
      OP_TRIM_RN,
      OP_TRIM_WN,
      OP_SEL_INIT,
      OP_SEL,
      OP_LOAD0,
      OP_LOAD1,
      OP_CLEAR
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } cmd_type;

   typedef struct packed {
      logic n_zero;
      logic n_one;
      logic walk_done;
      logic q_more;
      logic trim_go;
      logic nb_ok;
      logic have_b0;
      logic out_last;
      logic clr_done;
   } sts_type;

endpackage

### rtl/tcf_datapath.sv
// ----------------------------------------------------------------------------
// Tree centre finder datapath
// Degree, neighbour XOR and leaf queue memories with the registers that the
// controller steps through edge updates, leaf trimming and result selection.
// ----------------------------------------------------------------------------
module tcf_datapath #(
   parameter int MAX_NODES = 1024,
   parameter int AW        = $clog2(MAX_NODES),
   parameter int CW        = (AW + 1 > tcf_pkg::COUNT_W) ? AW + 1 : tcf_pkg::COUNT_W
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tcf_pkg::cmd_type             cmd,
   output tcf_pkg::sts_type             sts,
   input  logic [CW-1:0]                n_act,
   input  logic [tcf_pkg::LABEL_W-1:0]  req_node_a,
   input  logic [tcf_pkg::LABEL_W-1:0]  req_node_b,
   output logic [tcf_pkg::LABEL_W-1:0]  rsp_center_node,
   output logic                         rsp_last
);
   import tcf_pkg::*;

   localparam int QW = AW + 1;

   // Memories.
   logic [DEG_W-1:0]   deg_mem [MAX_NODES];
   logic [LABEL_W-1:0] xr_mem  [MAX_NODES];
   logic [LABEL_W-1:0] q_mem   [MAX_NODES];

   logic [DEG_W-1:0]   deg_rd_ff;
   logic [LABEL_W-1:0] xr_rd_ff;
   logic [LABEL_W-1:0] q_rd_ff;

   logic               deg_we, xr_we, q_we;
   logic [AW-1:0]      mem_raddr, mem_waddr, q_raddr;
   logic [DEG_W-1:0]   deg_wdata;
   logic [LABEL_W-1:0] xr_wdata;
   logic               push_en;
   logic [LABEL_W-1:0] push_val;

   // Working registers.
   logic [LABEL_W-1:0] a_ff, a_in, b_ff, b_in;
   logic               ok_ff, ok_in;
   logic [CW-1:0]      n_ff, n_in;
   logic [DEG_W-1:0]   fwd_deg_ff, fwd_deg_in;
   logic [LABEL_W-1:0] fwd_xr_ff, fwd_xr_in;
   logic [LABEL_W-1:0] cur_ff, cur_in, nb_ff, nb_in;
   logic               cur_ok_ff, cur_ok_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               pv_ff, pv_in;
   logic [LABEL_W-1:0] pidx_ff, pidx_in;
   logic [QW-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [QW-1:0]      lvl_start_ff, lvl_start_in, lvl_end_ff, lvl_end_in;
   logic [LABEL_W-1:0] b0_ff, b0_in, b1_ff, b1_in;
   logic               b0_vld_ff, b0_vld_in, b1_vld_ff, b1_vld_in;
   logic [LABEL_W-1:0] out_node_ff, out_node_in;
   logic               out_last_ff, out_last_in;

   logic               issue, lvl_more, q_more, trim_go, nb_ok, same_ab;
   logic [CW-1:0]      walk_lim;
   logic [DEG_W-1:0]   src_deg;
   logic [LABEL_W-1:0] src_xr;

   always_comb begin
      walk_lim = (cmd.op == OP_SEL) ? CW'(lvl_end_ff) : n_ff;
      issue    = cnt_ff < walk_lim;
      lvl_more = head_ff < lvl_end_ff;
      q_more   = head_ff < tail_ff;
      trim_go  = cur_ok_ff && (deg_rd_ff != '0);
      nb_ok    = CW'(xr_rd_ff) < n_ff;
      same_ab  = a_ff == b_ff;
      src_deg  = same_ab ? fwd_deg_ff : deg_rd_ff;
      src_xr   = same_ab ? fwd_xr_ff  : xr_rd_ff;

      sts.n_zero    = n_ff == '0;
      sts.n_one     = n_ff == CW'(1);
      sts.walk_done = !issue && !pv_ff;
      sts.q_more    = q_more;
      sts.trim_go   = trim_go;
      sts.nb_ok     = nb_ok;
      sts.have_b0   = b0_vld_ff;
      sts.out_last  = out_last_ff;
      sts.clr_done  = cnt_ff == CW'(MAX_NODES - 1);
   end

   always_comb begin
      a_in = a_ff;  b_in = b_ff;  ok_in = ok_ff;  n_in = n_ff;
      fwd_deg_in = fwd_deg_ff;  fwd_xr_in = fwd_xr_ff;
      cur_in = cur_ff;  cur_ok_in = cur_ok_ff;  nb_in = nb_ff;
      cnt_in = cnt_ff;  pv_in = pv_ff;  pidx_in = pidx_ff;
      head_in = head_ff;  tail_in = tail_ff;
      lvl_start_in = lvl_start_ff;  lvl_end_in = lvl_end_ff;
      b0_in = b0_ff;  b1_in = b1_ff;  b0_vld_in = b0_vld_ff;  b1_vld_in = b1_vld_ff;
      out_node_in = out_node_ff;  out_last_in = out_last_ff;

      deg_we = 1'b0;  xr_we = 1'b0;
      mem_raddr = '0;  mem_waddr = '0;  q_raddr = '0;
      deg_wdata = '0;  xr_wdata = '0;
      push_en = 1'b0;  push_val = '0;

      unique case (cmd.op)
         OP_ACCEPT: begin
            a_in      = req_node_a;
            b_in      = req_node_b;
            n_in      = n_act;
            ok_in     = (CW'(req_node_a) < n_act) && (CW'(req_node_b) < n_act);
            mem_raddr = AW'(req_node_a);
         end
         OP_EDGE_A: begin
            deg_wdata  = deg_rd_ff + DEG_W'(1);
            xr_wdata   = xr_rd_ff ^ b_ff;
            deg_we     = ok_ff;
            xr_we      = ok_ff;
            mem_waddr  = AW'(a_ff);
            mem_raddr  = AW'(b_ff);
            fwd_deg_in = deg_wdata;
            fwd_xr_in  = xr_wdata;
         end
         OP_EDGE_B: begin
            // A self loop reads back the entry just written for the first end.
            deg_wdata = src_deg + DEG_W'(1);
            xr_wdata  = src_xr ^ a_ff;
            deg_we    = ok_ff;
            xr_we     = ok_ff;
            mem_waddr = AW'(b_ff);
         end
         OP_FIND_INIT: begin
            cnt_in       = '0;
            pv_in        = 1'b0;
            head_in      = '0;
            tail_in      = '0;
            lvl_start_in = '0;
            lvl_end_in   = '0;
            out_node_in  = '0;
            out_last_in  = 1'b1;
         end
         OP_SCAN: begin
            mem_raddr = cnt_ff[AW-1:0];
            pv_in     = issue;
            pidx_in   = LABEL_W'(cnt_ff);
            if (issue) begin
               cnt_in = cnt_ff + CW'(1);
            end
            push_en  = pv_ff && (deg_rd_ff == DEG_W'(1));
            push_val = pidx_ff;
         end
         OP_LEVEL: begin
            if (!lvl_more && q_more) begin
               lvl_start_in = head_ff;
               lvl_end_in   = tail_ff;
            end
         end
         OP_TRIM_RQ: begin
            q_raddr = head_ff[AW-1:0];
            head_in = head_ff + QW'(1);
         end
         OP_TRIM_RC: begin
            cur_in    = q_rd_ff;
            cur_ok_in = CW'(q_rd_ff) < n_ff;
            mem_raddr = AW'(q_rd_ff);
         end
         OP_TRIM_CHK: begin
            nb_in     = xr_rd_ff;
            deg_we    = trim_go;
            deg_wdata = '0;
            mem_waddr = AW'(cur_ff);
         end
         OP_TRIM_RN: begin
            mem_raddr = AW'(nb_ff);
         end
         OP_TRIM_WN: begin
            mem_waddr = AW'(nb_ff);
            xr_we     = 1'b1;
            xr_wdata  = xr_rd_ff ^ cur_ff;
            deg_we    = deg_rd_ff != '0;
            deg_wdata = deg_rd_ff - DEG_W'(1);
            push_en   = deg_rd_ff == DEG_W'(2);
            push_val  = nb_ff;
         end
         OP_SEL_INIT: begin
            cnt_in    = CW'(lvl_start_ff);
            pv_in     = 1'b0;
            b0_vld_in = 1'b0;
            b1_vld_in = 1'b0;
         end
         OP_SEL: begin
            q_raddr = cnt_ff[AW-1:0];
            pv_in   = issue;
            if (issue) begin
               cnt_in = cnt_ff + CW'(1);
            end
            if (pv_ff) begin
               if (!b0_vld_ff || (q_rd_ff < b0_ff)) begin
                  b1_in     = b0_ff;
                  b1_vld_in = b0_vld_ff;
                  b0_in     = q_rd_ff;
                  b0_vld_in = 1'b1;
               end else if (!b1_vld_ff || (q_rd_ff < b1_ff)) begin
                  b1_in     = q_rd_ff;
                  b1_vld_in = 1'b1;
               end
            end
         end
         OP_LOAD0: begin
            cnt_in      = '0;
            out_node_in = b0_ff;
            out_last_in = !b1_vld_ff;
         end
         OP_LOAD1: begin
            out_node_in = b1_ff;
            out_last_in = 1'b1;
         end
         OP_CLEAR: begin
            deg_we    = 1'b1;
            xr_we     = 1'b1;
            mem_waddr = cnt_ff[AW-1:0];
            cnt_in    = cnt_ff + CW'(1);
         end
         default: begin
         end
      endcase

      q_we = push_en && (tail_ff < QW'(MAX_NODES));
      if (q_we) begin
         tail_in = tail_ff + QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (deg_we) begin
         deg_mem[mem_waddr] <= deg_wdata;
      end
      deg_rd_ff <= deg_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (xr_we) begin
         xr_mem[mem_waddr] <= xr_wdata;
      end
      xr_rd_ff <= xr_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (q_we) begin
         q_mem[tail_ff[AW-1:0]] <= push_val;
      end
      q_rd_ff <= q_mem[q_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         pv_ff        <= 1'b0;
         head_ff      <= '0;
         tail_ff      <= '0;
         lvl_start_ff <= '0;
         lvl_end_ff   <= '0;
         b0_vld_ff    <= 1'b0;
         b1_vld_ff    <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         pv_ff        <= pv_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         lvl_start_ff <= lvl_start_in;
         lvl_end_ff   <= lvl_end_in;
         b0_vld_ff    <= b0_vld_in;
         b1_vld_ff    <= b1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      b_ff        <= b_in;
      ok_ff       <= ok_in;
      n_ff        <= n_in;
      fwd_deg_ff  <= fwd_deg_in;
      fwd_xr_ff   <= fwd_xr_in;
      cur_ff      <= cur_in;
      cur_ok_ff   <= cur_ok_in;
      nb_ff       <= nb_in;
      pidx_ff     <= pidx_in;
      b0_ff       <= b0_in;
      b1_ff       <= b1_in;
      out_node_ff <= out_node_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_center_node = out_node_ff;
   assign rsp_last        = out_last_ff;

endmodule

### rtl/tcf_ctrl.sv
// ----------------------------------------------------------------------------
// Tree centre finder controller
// State machine that sequences edge updates, the find run and the clearing
// pass, and drives the channel handshakes.
// ----------------------------------------------------------------------------
module tcf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_func,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  tcf_pkg::sts_type  sts,
   output tcf_pkg::cmd_type  cmd
);
   import tcf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd.op    = OP_NONE;

      unique case (state_ff)
         ST_CLEAR: begin
            cmd.op = OP_CLEAR;
            if (sts.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.op   = OP_ACCEPT;
               state_in = (req_func == FUNC_FIND) ? ST_FIND : ST_EDGE_A;
            end
         end
         ST_EDGE_A: begin
            cmd.op   = OP_EDGE_A;
            state_in = ST_EDGE_B;
         end
         ST_EDGE_B: begin
            cmd.op   = OP_EDGE_B;
            state_in = ST_IDLE;
         end
         ST_FIND: begin
            cmd.op = OP_FIND_INIT;
            priority if (sts.n_zero) begin
               state_in = ST_CLEAR;
            end else if (sts.n_one) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.op = OP_SCAN;
            if (sts.walk_done) begin
               state_in = ST_LEVEL;
            end
         end
         ST_LEVEL: begin
            cmd.op   = OP_LEVEL;
            state_in = sts.q_more ? ST_TRIM_Q : ST_SEL_INIT;
         end
         ST_TRIM_Q: begin
            cmd.op   = OP_TRIM_RQ;
            state_in = ST_TRIM_C;
         end
         ST_TRIM_C: begin
            cmd.op   = OP_TRIM_RC;
            state_in = ST_TRIM_K;
         end
         ST_TRIM_K: begin
            cmd.op   = OP_TRIM_CHK;
            state_in = (sts.trim_go && sts.nb_ok) ? ST_TRIM_N : ST_LEVEL;
         end
         ST_TRIM_N: begin
            cmd.op   = OP_TRIM_RN;
            state_in = ST_TRIM_W;
         end
         ST_TRIM_W: begin
            cmd.op   = OP_TRIM_WN;
            state_in = ST_LEVEL;
         end
         ST_SEL_INIT: begin
            cmd.op   = OP_SEL_INIT;
            state_in = ST_SEL;
         end
         ST_SEL: begin
            cmd.op = OP_SEL;
            if (sts.walk_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cmd.op   = OP_LOAD0;
            state_in = sts.have_b0 ? ST_EMIT : ST_CLEAR;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               if (sts.out_last) begin
                  state_in = ST_CLEAR;
               end else begin
                  cmd.op = OP_LOAD1;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

### rtl/tree_center_finder.sv
// ----------------------------------------------------------------------------
// Tree centre finder
// Collects the edges of a tree and finds its one or two centres by trimming
// leaves level by level, returning the last level in ascending label order.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/stall     req_func, req_node_a, req_node_b
//   rsp      out        rsp_valid/stall     rsp_center_node, rsp_last
//   csr      in         APB-style, write    node_count at byte address 0
//
// An edge transaction on the degree and XOR memories reads the first end, updates
// it while reading the second, then updates that one.
// A find scans the nodes for leaves, then trims queued leaves level by level, each
// valid leaf updating its neighbour, then gives its results, then runs a clearing
// pass over all MAX_NODES entries, one entry a cycle; the same pass follows reset.
// req_stall stays high until the pass ends; a stalled result holds the emit state.
//
module tree_center_finder #(
   parameter int MAX_NODES = 1024
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_func,
   input  logic [tcf_pkg::LABEL_W-1:0]     req_node_a,
   input  logic [tcf_pkg::LABEL_W-1:0]     req_node_b,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tcf_pkg::LABEL_W-1:0]     rsp_center_node,
   output logic                            rsp_last,

   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [tcf_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [tcf_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [tcf_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import tcf_pkg::*;

   localparam int AW = $clog2(MAX_NODES);
   // The active count must hold both the 11-bit register and MAX_NODES itself.
   localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;

   logic [COUNT_W-1:0] node_count_ff, node_count_in;
   logic [CW-1:0]      count_ext, n_act;
   logic               csr_wr;
   cmd_type            cmd;
   sts_type            sts;

   // Configuration register. The word address bit selects the register; any
   // other register slot reads as zero and ignores writes.
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      node_count_in = node_count_ff;
      if (csr_wr && (csr_paddr[CSR_ADDR_W-1:2] == REG_NODE_COUNT)) begin
         node_count_in = csr_pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1:2] == REG_NODE_COUNT) begin
         csr_prdata = CSR_DATA_W'(node_count_ff);
      end
   end

   // A count above the memory depth behaves as the full depth.
   always_comb begin
      count_ext = CW'(node_count_ff);
      n_act     = (count_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : count_ext;
   end

   tcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tcf_datapath #(
      .MAX_NODES (MAX_NODES),
      .AW        (AW),
      .CW        (CW)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .n_act           (n_act),
      .req_node_a      (req_node_a),
      .req_node_b      (req_node_b),
      .rsp_center_node (rsp_center_node),
      .rsp_last        (rsp_last)
   );

   // The block never offers a result while it could take a new transaction.
   a_rsp_blocks_req : assert property (
      @(posedge clock) disable iff (reset) rsp_valid |-> req_stall
   ) else $error("result offered while requests are accepted");

   // Leaving reset starts the clearing pass, so requests are held off.
   a_reset_clears : assert property (
      @(posedge clock) disable iff (reset) $past(reset) |-> req_stall
   ) else $error("request accepted before the clearing pass");

   // An edge transaction holds off requests in ST_EDGE_A and ST_EDGE_B, then accepts again.
   a_edge_len : assert property (
      @(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_func == FUNC_EDGE))
         |=> req_stall ##1 req_stall ##1 !req_stall
   ) else $error("edge update did not take three cycles");

   // Nothing follows the final result of a find.
   a_last_ends : assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> !rsp_valid
   ) else $error("result offered after the final centre");

endmodule
